@@ hdl/psw_pkg.sv @@
// Shared types and constants for the point stability weights unit.
// No dependencies; every other file but psw_ram imports this package.
package psw_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int MAX_SAMPLES = 16;
    localparam int COORD_BITS  = 32;

    localparam int PT_W    = $clog2(MAX_POINTS);    // point index width
    localparam int NP_W    = PT_W + 1;              // point count width
    localparam int SLOT_W  = $clog2(MAX_SAMPLES);   // sample slot width
    localparam int NS_W    = SLOT_W + 1;            // sample count width
    localparam int DIST_W  = 32;                    // Q16.16 distance
    localparam int DSUM_W  = DIST_W + SLOT_W;       // per-point distance sum
    localparam int CSUM_W  = COORD_BITS + PT_W;     // coordinate sum per axis
    localparam int CEN_W   = COORD_BITS + 1;        // centroid, signed
    localparam int DIFF_W  = COORD_BITS + 2;        // coordinate minus centroid
    localparam int DEV_W   = DSUM_W;                // |n*d - T|
    localparam int DIV_W   = 78;                    // divider dividend / quotient
    localparam int DIVS_W  = 32;                    // divider divisor
    localparam int LEN_W   = 7;                     // divider step count
    localparam int RAD_W   = 64;                    // square root radicand
    localparam int ROOT_W  = 32;                    // square root result
    localparam int DVSR_W  = 12;                    // n*n*(n-1)
    localparam int CFG_W   = 7;                     // widest register

    // Register indexes of the configuration port
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_NUM_POINTS  = 1'b0;
    localparam t_cfg_idx CFG_NUM_SAMPLES = 1'b1;

    // One classified point on its way from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [PT_W-1:0]       pt;
        logic                  sample_end;
        logic                  run_end;
        logic [SLOT_W-1:0]     slot;
        logic [NP_W-1:0]       np;
        logic [NS_W-1:0]       ns;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dvd;     // dividend, left aligned
        logic [DIVS_W-1:0] dvs;
        logic [LEN_W-1:0]  len;     // number of quotient bits
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] rad;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

@@ hdl/psw_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module psw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write, then register the read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/psw_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on psw_pkg.
module psw_div import psw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [LEN_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [DIV_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_quo;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    // Trial subtract of the next dividend bit
    always_comb begin
        trial = {r_rem, r_dvd[DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= i_req.len;
                r_rem  <= '0;
                r_dvs  <= i_req.dvs;
                r_dvd  <= i_req.dvd;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem  <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
                r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
                r_quo  <= {r_quo[DIV_W-2:0], ge};
                r_cnt  <= r_cnt - LEN_W'(1);
                r_done <= r_cnt == LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

@@ hdl/psw_sqrt.sv @@
// Digit by digit integer square root, one result bit per cycle.
// Depends on psw_pkg.
module psw_sqrt import psw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    localparam int CNT_W = $clog2(ROOT_W) + 1;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [ROOT_W+1:0] rem2;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        rem2  = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
        trial = {r_root, 2'b01};
        ge    = rem2 >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNT_W'(ROOT_W);
                r_rad  <= i_req.rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= ge ? (rem2 - trial) : rem2;
                r_root <= {r_root[ROOT_W-2:0], ge};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= r_cnt == CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

@@ hdl/psw_queue.sv @@
// Two entry queue of classified points between front and back.
// Depends on psw_pkg.
module psw_queue import psw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // Storage needs no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];

endmodule

@@ hdl/psw_front.sv @@
// Front end: configuration registers, point and sample counting, item tagging.
// Depends on psw_pkg.
module psw_front import psw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic [COORD_BITS-1:0] i_coord_z,
    output logic                  o_push,
    output t_item                 o_item,
    input  logic                  i_full
);

    logic [NP_W-1:0] r_num_points;
    logic [NS_W-1:0] r_num_samples;
    logic [NP_W-1:0] r_pt_cnt;
    logic [NS_W-1:0] r_smp_cnt;

    logic [NP_W-1:0]   np_eff;
    logic [NS_W-1:0]   ns_eff;
    logic [PT_W-1:0]   pt;
    logic [SLOT_W-1:0] slot;
    logic [NP_W-1:0]   pc1;
    logic [NS_W-1:0]   sc1;
    logic              sample_end;
    logic              run_end;
    logic              xfer;

    // Clamp registers into their working range
    always_comb begin
        if (r_num_points == '0) begin
            np_eff = NP_W'(1);
        end else if (r_num_points > NP_W'(MAX_POINTS)) begin
            np_eff = NP_W'(MAX_POINTS);
        end else begin
            np_eff = r_num_points;
        end
        if (r_num_samples < NS_W'(2)) begin
            ns_eff = NS_W'(2);
        end else if (r_num_samples > NS_W'(MAX_SAMPLES)) begin
            ns_eff = NS_W'(MAX_SAMPLES);
        end else begin
            ns_eff = r_num_samples;
        end
    end

    // Classify the incoming point
    always_comb begin
        pt         = r_pt_cnt[PT_W-1:0];
        slot       = r_smp_cnt[SLOT_W-1:0];
        pc1        = {1'b0, pt} + NP_W'(1);
        sc1        = {1'b0, slot} + NS_W'(1);
        sample_end = pc1 >= np_eff;
        run_end    = sample_end && (sc1 >= ns_eff);
        xfer       = i_in_valid && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points  <= NP_W'(MAX_POINTS);
            r_num_samples <= NS_W'(MAX_SAMPLES);
            r_pt_cnt      <= '0;
            r_smp_cnt     <= '0;
        end else begin
            // Configuration writes
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    CFG_NUM_POINTS:  r_num_points  <= i_cfg_wr_data[NP_W-1:0];
                    CFG_NUM_SAMPLES: r_num_samples <= i_cfg_wr_data[NS_W-1:0];
                    default: ;
                endcase
            end
            // Advance counters on each transfer
            if (xfer) begin
                r_pt_cnt <= sample_end ? '0 : pc1;
                if (sample_end) begin
                    r_smp_cnt <= run_end ? '0 : sc1;
                end
            end
        end
    end

    assign o_in_ready         = !i_full;
    assign o_push             = xfer;
    assign o_item.x           = i_coord_x;
    assign o_item.y           = i_coord_y;
    assign o_item.z           = i_coord_z;
    assign o_item.pt          = pt;
    assign o_item.sample_end  = sample_end;
    assign o_item.run_end     = run_end;
    assign o_item.slot        = slot;
    assign o_item.np          = np_eff;
    assign o_item.ns          = ns_eff;

endmodule

@@ hdl/psw_back.sv @@
// Back end: point store, per-sample centroid and distances, per-run spread and weight.
// Depends on psw_pkg, psw_ram, psw_div and psw_sqrt.
module psw_back import psw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PT_W-1:0]   o_point_index,
    output logic [DIST_W-1:0] o_spread,
    output logic [DIST_W-1:0] o_weight,
    output logic              o_zero_spread,
    output logic              o_last_result
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SUM, ST_SUM_LAST, ST_CEN, ST_CEN_WAIT,
        ST_D_RD, ST_D_SUB, ST_D_M0, ST_D_M1, ST_D_M2, ST_D_M3,
        ST_D_SQ, ST_D_SQW, ST_D_WR,
        ST_R_RD, ST_R_MAG, ST_R_MUL, ST_R_ACC, ST_R_DIV, ST_R_DWAIT,
        ST_R_SWAIT, ST_R_WDIV, ST_R_WWAIT, ST_R_OUT
    } t_state;

    t_state              r_state;
    logic [PT_W-1:0]     r_idx;
    logic [SLOT_W-1:0]   r_sidx;
    logic [SLOT_W-1:0]   r_slot;
    logic [NP_W-1:0]     r_np;
    logic [NS_W-1:0]     r_ns;
    logic                r_run_end;
    logic [DVSR_W-1:0]   r_divisor;
    logic                r_sum_pipe;
    logic [CSUM_W-1:0]   r_csum [3];
    logic [CEN_W-1:0]    r_cen [3];
    logic [1:0]          r_axis;
    logic [DIST_W-1:0]   r_ax;
    logic [DIST_W-1:0]   r_ay;
    logic [DIST_W-1:0]   r_az;
    logic [2*DIST_W-1:0] r_prod;
    logic [DIST_W+3:0]   r_p1;
    logic [7:0]          r_p2;
    logic [DEV_W-1:0]    r_m;
    logic [DIV_W-1:0]    r_acc;
    logic [DIST_W-1:0]   r_dist;
    logic                r_qsat;
    logic [DIST_W-1:0]   r_spread;
    logic [DIST_W-1:0]   r_weight;
    logic [MAX_POINTS-1:0] r_sum_vld;
    logic                r_out_vld;
    logic [PT_W-1:0]     r_out_pt;
    logic [DIST_W-1:0]   r_out_spread;
    logic [DIST_W-1:0]   r_out_weight;
    logic                r_out_zero;
    logic                r_out_last;

    logic [COORD_BITS-1:0] cur_x_rd;
    logic [COORD_BITS-1:0] cur_y_rd;
    logic [COORD_BITS-1:0] cur_z_rd;
    logic [DIST_W-1:0]     dstore_rd;
    logic [DSUM_W-1:0]     dsum_rd;
    logic [DSUM_W-1:0]     dsum_old;
    logic [DSUM_W-1:0]     dsum_new;
    logic                  dist_we;
    logic [DIST_W-1:0]     dist_val;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_sqrt_req sqrt_req;
    t_sqrt_rsp sqrt_rsp;

    logic [CSUM_W-1:0]   cen_sum;
    logic                cen_neg;
    logic [CSUM_W:0]     cen_mag;
    logic [CEN_W-1:0]    cen_q;
    logic [CEN_W-1:0]    cen_val;
    logic [DIFF_W-1:0]   dx;
    logic [DIFF_W-1:0]   dy;
    logic [DIFF_W-1:0]   dz;
    logic [DIFF_W-1:0]   adx;
    logic [DIFF_W-1:0]   ady;
    logic [DIFF_W-1:0]   adz;
    logic [DIST_W-1:0]   mul_a;
    logic [DEV_W:0]      scaled;
    logic [DEV_W:0]      dev;
    logic [DIV_W-1:0]    acc_add;
    logic                idx_last;
    logic                sidx_last;
    logic                out_free;
    logic [DVSR_W-1:0]   item_divisor;

    // Point, distance and distance-sum stores
    psw_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_cur_x (
        .i_clk(i_clk), .i_wr_en(o_pop), .i_wr_addr(i_item.pt), .i_wr_data(i_item.x),
        .i_rd_addr(r_idx), .o_rd_data(cur_x_rd)
    );
    psw_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_cur_y (
        .i_clk(i_clk), .i_wr_en(o_pop), .i_wr_addr(i_item.pt), .i_wr_data(i_item.y),
        .i_rd_addr(r_idx), .o_rd_data(cur_y_rd)
    );
    psw_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_cur_z (
        .i_clk(i_clk), .i_wr_en(o_pop), .i_wr_addr(i_item.pt), .i_wr_data(i_item.z),
        .i_rd_addr(r_idx), .o_rd_data(cur_z_rd)
    );
    psw_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS*MAX_SAMPLES)) u_dist_store (
        .i_clk(i_clk), .i_wr_en(dist_we), .i_wr_addr({r_slot, r_idx}),
        .i_wr_data(dist_val), .i_rd_addr({r_sidx, r_idx}), .o_rd_data(dstore_rd)
    );
    psw_ram #(.WIDTH(DSUM_W), .DEPTH(MAX_POINTS)) u_dist_sum (
        .i_clk(i_clk), .i_wr_en(dist_we), .i_wr_addr(r_idx), .i_wr_data(dsum_new),
        .i_rd_addr(r_idx), .o_rd_data(dsum_rd)
    );

    psw_div  u_div  (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),  .o_rsp(div_rsp));
    psw_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sqrt_req), .o_rsp(sqrt_rsp));

    // Pop whenever the back end is idle
    assign o_pop = (r_state == ST_IDLE) && i_q_valid;

    // Loop bounds and output slot
    always_comb begin
        idx_last     = {1'b0, r_idx} == (r_np - NP_W'(1));
        sidx_last    = {1'b0, r_sidx} == (r_ns - NS_W'(1));
        out_free     = !r_out_vld || i_out_ready;
        item_divisor = DVSR_W'(DVSR_W'(i_item.ns) * DVSR_W'(i_item.ns)
                       * DVSR_W'(i_item.ns - NS_W'(1)));
    end

    // Centroid: floor division of the axis sum by the point count
    always_comb begin
        cen_sum = r_csum[r_axis];
        cen_neg = cen_sum[CSUM_W-1];
        if (cen_neg) begin
            cen_mag = (CSUM_W+1)'(0) - {cen_sum[CSUM_W-1], cen_sum}
                      + (CSUM_W+1)'(r_np) - (CSUM_W+1)'(1);
        end else begin
            cen_mag = {1'b0, cen_sum};
        end
        cen_q   = div_rsp.quo[CEN_W-1:0];
        cen_val = cen_neg ? (CEN_W'(0) - cen_q) : cen_q;
    end

    // Absolute distance from the centroid per axis
    always_comb begin
        dx  = {{2{cur_x_rd[COORD_BITS-1]}}, cur_x_rd} - {r_cen[0][CEN_W-1], r_cen[0]};
        dy  = {{2{cur_y_rd[COORD_BITS-1]}}, cur_y_rd} - {r_cen[1][CEN_W-1], r_cen[1]};
        dz  = {{2{cur_z_rd[COORD_BITS-1]}}, cur_z_rd} - {r_cen[2][CEN_W-1], r_cen[2]};
        adx = dx[DIFF_W-1] ? (DIFF_W'(0) - dx) : dx;
        ady = dy[DIFF_W-1] ? (DIFF_W'(0) - dy) : dy;
        adz = dz[DIFF_W-1] ? (DIFF_W'(0) - dz) : dz;
    end

    // Shared squarer operand
    always_comb begin
        unique case (r_state)
            ST_D_M0: mul_a = r_ax;
            ST_D_M1: mul_a = r_ay;
            ST_D_M2: mul_a = r_az;
            default: mul_a = r_m[DIST_W-1:0];
        endcase
    end

    // Deviation of one scaled distance from the run sum
    always_comb begin
        scaled = (DEV_W+1)'(r_ns) * (DEV_W+1)'(dstore_rd);
        if (scaled >= {1'b0, dsum_old}) begin
            dev = scaled - {1'b0, dsum_old};
        end else begin
            dev = {1'b0, dsum_old} - scaled;
        end
        acc_add = DIV_W'(r_prod) + (DIV_W'(r_p1) << (DIST_W + 1))
                  + (DIV_W'(r_p2) << (2*DIST_W));
    end

    // Distance write back
    always_comb begin
        dsum_old = r_sum_vld[r_idx] ? dsum_rd : '0;
        dist_val = (r_acc[2*DIST_W+1:2*DIST_W] != 2'b00) ? '1 : r_dist;
        dsum_new = dsum_old + DSUM_W'(dist_val);
        dist_we  = r_state == ST_D_WR;
    end

    // Requests to the divider and the square root unit
    always_comb begin
        div_req.start = 1'b0;
        div_req.dvd   = '0;
        div_req.dvs   = '0;
        div_req.len   = '0;
        unique case (r_state)
            ST_CEN: begin
                div_req.start = 1'b1;
                div_req.dvd   = {cen_mag[CSUM_W-1:0], {(DIV_W-CSUM_W){1'b0}}};
                div_req.dvs   = DIVS_W'(r_np);
                div_req.len   = LEN_W'(CSUM_W);
            end
            ST_R_DIV: begin
                div_req.start = 1'b1;
                div_req.dvd   = r_acc;
                div_req.dvs   = DIVS_W'(r_divisor);
                div_req.len   = LEN_W'(DIV_W);
            end
            ST_R_WDIV: begin
                div_req.start = r_spread != '0;
                div_req.dvd   = {1'b1, {(DIV_W-1){1'b0}}} >> (DIV_W - DIST_W - 1);
                div_req.dvd   = div_req.dvd << (DIV_W - DIST_W - 1);
                div_req.dvs   = r_spread;
                div_req.len   = LEN_W'(DIST_W + 1);
            end
            default: ;
        endcase
        sqrt_req.start = (r_state == ST_D_SQ) || ((r_state == ST_R_DWAIT) && div_rsp.done);
        sqrt_req.rad   = (r_state == ST_D_SQ) ? r_acc[RAD_W-1:0] : div_rsp.quo[RAD_W-1:0];
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_sum_pipe <= 1'b0;
            r_sum_vld  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_prod     <= mul_a * mul_a;
            r_sum_pipe <= r_state == ST_SUM;
            if (r_sum_pipe) begin
                r_csum[0] <= r_csum[0] + CSUM_W'(signed'(cur_x_rd));
                r_csum[1] <= r_csum[1] + CSUM_W'(signed'(cur_y_rd));
                r_csum[2] <= r_csum[2] + CSUM_W'(signed'(cur_z_rd));
            end
            if (r_out_vld && i_out_ready && (r_state != ST_R_OUT)) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                // Store points; start the sample pass on its last point
                ST_IDLE: begin
                    if (o_pop && i_item.sample_end) begin
                        r_np      <= i_item.np;
                        r_ns      <= i_item.ns;
                        r_slot    <= i_item.slot;
                        r_run_end <= i_item.run_end;
                        r_divisor <= item_divisor;
                        r_idx     <= '0;
                        r_csum[0] <= '0;
                        r_csum[1] <= '0;
                        r_csum[2] <= '0;
                        r_state   <= ST_SUM;
                    end
                end
                // Read the points back and sum each axis
                ST_SUM: begin
                    if (idx_last) begin
                        r_state <= ST_SUM_LAST;
                    end else begin
                        r_idx <= r_idx + PT_W'(1);
                    end
                end
                ST_SUM_LAST: begin
                    r_axis  <= 2'd0;
                    r_state <= ST_CEN;
                end
                ST_CEN: begin
                    r_state <= ST_CEN_WAIT;
                end
                ST_CEN_WAIT: begin
                    if (div_rsp.done) begin
                        r_cen[r_axis] <= cen_val;
                        if (r_axis == 2'd2) begin
                            r_idx   <= '0;
                            r_state <= ST_D_RD;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= ST_CEN;
                        end
                    end
                end
                // Distance of one point: three squares, then root
                ST_D_RD: begin
                    r_state <= ST_D_SUB;
                end
                ST_D_SUB: begin
                    r_ax    <= adx[DIST_W-1:0];
                    r_ay    <= ady[DIST_W-1:0];
                    r_az    <= adz[DIST_W-1:0];
                    r_state <= ST_D_M0;
                end
                ST_D_M0: begin
                    r_state <= ST_D_M1;
                end
                ST_D_M1: begin
                    r_acc   <= DIV_W'(r_prod);
                    r_state <= ST_D_M2;
                end
                ST_D_M2: begin
                    r_acc   <= r_acc + DIV_W'(r_prod);
                    r_state <= ST_D_M3;
                end
                ST_D_M3: begin
                    r_acc   <= r_acc + DIV_W'(r_prod);
                    r_state <= ST_D_SQ;
                end
                ST_D_SQ: begin
                    r_state <= ST_D_SQW;
                end
                ST_D_SQW: begin
                    if (sqrt_rsp.done) begin
                        r_dist  <= sqrt_rsp.root;
                        r_state <= ST_D_WR;
                    end
                end
                ST_D_WR: begin
                    r_sum_vld[r_idx] <= 1'b1;
                    if (idx_last) begin
                        if (r_run_end) begin
                            r_idx   <= '0;
                            r_sidx  <= '0;
                            r_acc   <= '0;
                            r_state <= ST_R_RD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_idx   <= r_idx + PT_W'(1);
                        r_state <= ST_D_RD;
                    end
                end
                // Sum of squared deviations over the samples of one point
                ST_R_RD: begin
                    r_state <= ST_R_MAG;
                end
                ST_R_MAG: begin
                    r_m     <= dev[DEV_W-1:0];
                    r_state <= ST_R_MUL;
                end
                ST_R_MUL: begin
                    r_p1    <= (DIST_W+4)'(r_m[DIST_W-1:0]) * (DIST_W+4)'(r_m[DEV_W-1:DIST_W]);
                    r_p2    <= 8'(r_m[DEV_W-1:DIST_W]) * 8'(r_m[DEV_W-1:DIST_W]);
                    r_state <= ST_R_ACC;
                end
                ST_R_ACC: begin
                    r_acc <= r_acc + acc_add;
                    if (sidx_last) begin
                        r_state <= ST_R_DIV;
                    end else begin
                        r_sidx  <= r_sidx + SLOT_W'(1);
                        r_state <= ST_R_RD;
                    end
                end
                ST_R_DIV: begin
                    r_state <= ST_R_DWAIT;
                end
                ST_R_DWAIT: begin
                    if (div_rsp.done) begin
                        r_qsat  <= div_rsp.quo[DIV_W-1:RAD_W] != '0;
                        r_state <= ST_R_SWAIT;
                    end
                end
                ST_R_SWAIT: begin
                    if (sqrt_rsp.done) begin
                        r_spread <= r_qsat ? '1 : sqrt_rsp.root;
                        r_state  <= ST_R_WDIV;
                    end
                end
                ST_R_WDIV: begin
                    if (r_spread == '0) begin
                        r_weight <= '1;
                        r_state  <= ST_R_OUT;
                    end else begin
                        r_state  <= ST_R_WWAIT;
                    end
                end
                ST_R_WWAIT: begin
                    if (div_rsp.done) begin
                        r_weight <= (div_rsp.quo[DIV_W-1:DIST_W] != '0) ? '1
                                    : div_rsp.quo[DIST_W-1:0];
                        r_state  <= ST_R_OUT;
                    end
                end
                // Hand the result to the output register
                ST_R_OUT: begin
                    if (out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_pt     <= r_idx;
                        r_out_spread <= r_spread;
                        r_out_weight <= r_weight;
                        r_out_zero   <= r_spread == '0;
                        r_out_last   <= idx_last;
                        if (idx_last) begin
                            r_sum_vld <= '0;
                            r_state   <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + PT_W'(1);
                            r_sidx  <= '0;
                            r_acc   <= '0;
                            r_state <= ST_R_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_point_index = r_out_pt;
    assign o_spread      = r_out_spread;
    assign o_weight      = r_out_weight;
    assign o_zero_spread = r_out_zero;
    assign o_last_result = r_out_last;

endmodule

@@ hdl/shape_point_stability_weights_unit.sv @@
// Top level of the point stability weights unit: front end, queue, back end.
// Depends on psw_pkg, psw_front, psw_queue and psw_back.
//
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     i_coord_x, i_coord_y, i_coord_z
//  out       output     o_out_valid / i_out_ready   o_point_index, o_spread, o_weight,
//                                                   o_zero_spread, o_last_result
//  cfg       input      i_cfg_wr_en                 i_cfg_idx, i_cfg_wr_data
//
// A point that does not end a sample is stored while the back end is idle; the front end
// takes one point per cycle while the two entry queue has room.
// A sample end costs np reads, three 38 step divisions and, per point, three
// squares plus a 32 step root in the back end.
// A run end adds, per point, a pass over its ns samples, the shared
// 78 step divider and the 32 step root; results wait in one output register.
// Reset is synchronous and active low and clears all control state.
module shape_point_stability_weights_unit import psw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic [COORD_BITS-1:0] i_coord_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PT_W-1:0]       o_point_index,
    output logic [DIST_W-1:0]     o_spread,
    output logic [DIST_W-1:0]     o_weight,
    output logic                  o_zero_spread,
    output logic                  o_last_result
);

    t_item push_item;
    t_item pop_item;
    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;

    psw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_idx(i_cfg_idx), .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .o_push(push), .o_item(push_item), .i_full(full)
    );

    psw_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_item(push_item), .o_full(full),
        .i_pop(pop), .o_valid(q_valid), .o_item(pop_item)
    );

    psw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_item(pop_item), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_point_index(o_point_index), .o_spread(o_spread), .o_weight(o_weight),
        .o_zero_spread(o_zero_spread), .o_last_result(o_last_result)
    );

endmodule

@@ hdl/psw_checker.sv @@
// Port level checks for the point stability weights unit, bound to the top level.
// Depends on psw_pkg and shape_point_stability_weights_unit.
module psw_checker import psw_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [PT_W-1:0]       o_point_index,
    input logic [DIST_W-1:0]     o_spread,
    input logic [DIST_W-1:0]     o_weight,
    input logic                  o_zero_spread,
    input logic                  o_last_result
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_point_index)
        && $stable(o_spread) && $stable(o_weight))
        else $error("result changed while stalled");

    // Zero spread saturates the weight
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_spread |-> o_spread == '0 && o_weight == '1)
        else $error("zero spread flag inconsistent");

    // Spread of one LSB saturates the weight without the flag
    a_one_lsb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_spread == DIST_W'(1) |-> !o_zero_spread && o_weight == '1)
        else $error("one LSB spread weight wrong");

    // A run ends with its last result; nothing follows at once
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_result |=> !o_out_valid)
        else $error("result after last result");

    // Reset drops the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind shape_point_stability_weights_unit psw_checker u_psw_checker (.*);

@@ verif/tb_top.sv @@
// Testbench for shape_point_stability_weights_unit: a short directed table, then
// random shape samples, all checked against a behavioral landmark weight predictor.
// Depends on psw_pkg and the RTL of the unit.
module tb_top;
    import psw_pkg::*;

    typedef struct {
        logic [PT_W-1:0] idx;
        logic [31:0]     spread;
        logic [31:0]     weight;
        logic            zero;
        logic            last;
    } t_weight_res;

    typedef struct {
        bit          cfg;
        logic [6:0]  np_raw;
        logic [6:0]  ns_raw;
        logic [31:0] x, y, z;
        bit          chk;
        logic [31:0] es, ew;
        logic        ez;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    t_cfg_idx              i_cfg_idx = CFG_NUM_POINTS;
    logic [CFG_W-1:0]      i_cfg_wr_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [COORD_BITS-1:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PT_W-1:0]       o_point_index;
    logic [DIST_W-1:0]     o_spread, o_weight;
    logic                  o_zero_spread, o_last_result;

    shape_point_stability_weights_unit u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    logic [6:0]  pts_reg = 7'd64;
    logic [4:0]  smp_reg = 5'd16;
    logic [31:0] cur_x[64], cur_y[64], cur_z[64];
    logic [31:0] dist_mem[1024];
    logic [63:0] dist_acc[64];
    int          pt_cnt = 0, smp_cnt = 0;

    t_weight_res weights_due[$];
    int          err_cnt = 0;
    bit          hold_go = 1'b0;
    bit          hold_on = 1'b0;
    int          items_sent = 0;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int eff_pts();
        if (pts_reg < 1) return 1;
        if (pts_reg > MAX_POINTS) return MAX_POINTS;
        return pts_reg;
    endfunction

    function automatic int eff_smp();
        if (smp_reg < 2) return 2;
        if (smp_reg > MAX_SAMPLES) return MAX_SAMPLES;
        return smp_reg;
    endfunction

    function automatic longint floor_mean(input longint s, input int n);
        if (s >= 0) return s / n;
        return -((-s + n - 1) / n);
    endfunction

    // Centroid distances of a completed sample
    task automatic close_sample(input int np, input int slot);
        longint sx, sy, sz, cx, cy, cz, dx, dy, dz;
        logic [127:0] sq;
        logic [31:0] d;
        sx = 0; sy = 0; sz = 0;
        for (int p = 0; p < np; p++) begin
            sx += longint'($signed(cur_x[p]));
            sy += longint'($signed(cur_y[p]));
            sz += longint'($signed(cur_z[p]));
        end
        cx = floor_mean(sx, np);
        cy = floor_mean(sy, np);
        cz = floor_mean(sz, np);
        for (int p = 0; p < np; p++) begin
            dx = longint'($signed(cur_x[p])) - cx;
            dy = longint'($signed(cur_y[p])) - cy;
            dz = longint'($signed(cur_z[p])) - cz;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dz < 0) dz = -dz;
            sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
            d = (sq[127:64] != 0) ? 32'hFFFF_FFFF : 32'(root64(sq[63:0]));
            dist_mem[slot * MAX_POINTS + p] = d;
            dist_acc[p] += 64'(d);
        end
    endtask

    // Take one point; queue the landmark weights when it closes a run
    task automatic landmark_step(input logic [31:0] x, y, z);
        int np, ns, p;
        logic [63:0] n, t, a, m;
        logic [127:0] acc, q;
        t_weight_res r;
        np = eff_pts();
        ns = eff_smp();
        p = pt_cnt % MAX_POINTS;
        cur_x[p] = x; cur_y[p] = y; cur_z[p] = z;
        pt_cnt = p + 1;
        if (pt_cnt < np) return;
        pt_cnt = 0;
        close_sample(np, smp_cnt % MAX_SAMPLES);
        smp_cnt = smp_cnt % MAX_SAMPLES + 1;
        if (smp_cnt < ns) return;
        n = 64'(ns);
        for (int k = 0; k < np; k++) begin
            t = dist_acc[k];
            acc = 0;
            for (int s = 0; s < ns; s++) begin
                a = n * 64'(dist_mem[s * MAX_POINTS + k]);
                m = (a >= t) ? a - t : t - a;
                acc += 128'(m) * 128'(m);
            end
            q = acc / 128'(n * n * (n - 1));
            r.idx = PT_W'(k);
            r.spread = (q[127:64] != 0) ? 32'hFFFF_FFFF : 32'(root64(q[63:0]));
            if (r.spread == 0) r.weight = 32'hFFFF_FFFF;
            else if ((64'h1_0000_0000 / r.spread) > 64'hFFFF_FFFF) r.weight = 32'hFFFF_FFFF;
            else r.weight = 32'(64'h1_0000_0000 / r.spread);
            r.zero = (r.spread == 0);
            r.last = (k + 1 == np);
            weights_due.push_back(r);
        end
        smp_cnt = 0;
        for (int k = 0; k < 64; k++) dist_acc[k] = 0;
    endtask

    // Wait for all results, let the block settle, then write both registers
    task automatic set_shape(input logic [6:0] np_raw, input logic [6:0] ns_raw);
        i_in_valid <= 1'b0;
        while (weights_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_idx     <= CFG_NUM_POINTS;
        i_cfg_wr_data <= np_raw;
        @(posedge i_clk);
        i_cfg_idx     <= CFG_NUM_SAMPLES;
        i_cfg_wr_data <= ns_raw;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pts_reg = np_raw;
        smp_reg = ns_raw[4:0];
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one point and hold it until the transfer
    task automatic send_point(input logic [31:0] x, y, z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_coord_x  <= x;
        i_coord_y  <= y;
        i_coord_z  <= z;
        landmark_step(x, y, z);
        items_sent++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        if (mode == 0) return $urandom;
        if (mode == 1) return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
        return 32'($signed($urandom_range(0, 32'h0000_0400)) - 32'h0000_0200);
    endfunction

    // Hold the receiver off for a long stretch once asked
    initial begin
        wait (hold_go);
        hold_on = 1'b1;
        repeat (10000) @(posedge i_clk);
        hold_on = 1'b0;
    end

    // Check each result transfer and drive ready
    initial begin
        int stall;
        t_weight_res e;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (weights_due.size() == 0) begin
                    $display("%0t: unexpected result, point %0d", $time, o_point_index);
                    err_cnt++;
                end else begin
                    e = weights_due.pop_front();
                    if (o_point_index !== e.idx) begin
                        $display("%0t: point_index exp %0d got %0d", $time, e.idx, o_point_index);
                        err_cnt++;
                    end
                    if (o_spread !== e.spread) begin
                        $display("%0t: spread exp %h got %h", $time, e.spread, o_spread);
                        err_cnt++;
                    end
                    if (o_weight !== e.weight) begin
                        $display("%0t: weight exp %h got %h", $time, e.weight, o_weight);
                        err_cnt++;
                    end
                    if (o_zero_spread !== e.zero) begin
                        $display("%0t: zero_spread exp %b got %b", $time, e.zero, o_zero_spread);
                        err_cnt++;
                    end
                    if (o_last_result !== e.last) begin
                        $display("%0t: last_result exp %b got %b", $time, e.last, o_last_result);
                        err_cnt++;
                    end
                end
            end
            // Hold off for a long stretch on request, else stall at random
            if (hold_on) begin
                i_out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Directed table: zero spread with register floors, saturated distance,
    // spread of one LSB
    t_row dir_tab[12] = '{
        '{1, 7'd0,  7'd1,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0, 0, 0, 0},
        '{0, 7'd0,  7'd0,  32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 1, 0, 32'hFFFF_FFFF, 1},
        '{1, 7'd3,  7'h62, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{0, 7'd0,  7'd0,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{0, 7'd0,  7'd0,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0},
        '{0, 7'd0,  7'd0,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{0, 7'd0,  7'd0,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{0, 7'd0,  7'd0,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 32'hFFFF_FFFF, 1},
        '{1, 7'd2,  7'd2,  32'h0, 32'h0, 32'h0, 0, 0, 0, 0},
        '{0, 7'd0,  7'd0,  32'h2, 32'h0, 32'h0, 0, 0, 0, 0},
        '{0, 7'd0,  7'd0,  32'h0, 32'h0, 32'h0, 0, 0, 0, 0},
        '{0, 7'd0,  7'd0,  32'h6, 32'h0, 32'h0, 1, 1, 32'hFFFF_FFFF, 0}
    };

    initial begin
        int q0, sel, runs, mode, ns;
        logic [6:0] np_raw, ns_raw;
        bit pressed;
        pressed = 0;
        for (int k = 0; k < 64; k++) dist_acc[k] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg) set_shape(dir_tab[i].np_raw, dir_tab[i].ns_raw);
            q0 = weights_due.size();
            send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z);
            if (dir_tab[i].chk) begin
                for (int k = q0; k < weights_due.size(); k++) begin
                    if (weights_due[k].spread !== dir_tab[i].es ||
                        weights_due[k].weight !== dir_tab[i].ew ||
                        weights_due[k].zero !== dir_tab[i].ez) begin
                        $display("%0t: table row %0d exp %h/%h/%b got %h/%h/%b", $time, i,
                                 dir_tab[i].es, dir_tab[i].ew, dir_tab[i].ez,
                                 weights_due[k].spread, weights_due[k].weight,
                                 weights_due[k].zero);
                        err_cnt++;
                    end
                end
            end
        end

        // Random runs over several shapes, extremes included
        while (items_sent < 455) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                np_raw = $urandom_range(0, 1) ? 7'd64 : 7'd127;
                ns_raw = {2'($urandom_range(0, 3)), 5'($urandom_range(0, 2))};
            end else if (sel == 1) begin
                np_raw = 7'($urandom_range(0, 1));
                ns_raw = {2'($urandom_range(0, 3)), $urandom_range(0, 1) ? 5'd16 : 5'd31};
            end else begin
                np_raw = 7'($urandom_range(2, 8));
                ns_raw = {2'($urandom_range(0, 3)), 5'($urandom_range(2, 6))};
            end
            set_shape(np_raw, ns_raw);
            ns = eff_smp();
            runs = (sel <= 1) ? 1 : $urandom_range(1, 2);
            // Keep offering a second run while the results are held off
            if (!pressed && sel > 1) begin
                runs    = 2;
                hold_go = 1'b1;
                pressed = 1;
            end
            for (int r = 0; r < runs; r++) begin
                for (int s = 0; s < ns; s++) begin
                    mode = $urandom_range(0, 3);
                    if (mode == 3) mode = 1;
                    for (int p = 0; p < eff_pts(); p++)
                        send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode));
                end
            end
        end
        i_in_valid <= 1'b0;

        while (weights_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
